// File: rtl/psi_pkg.sv
// ----------------------------------------------------------------------------
// psi_pkg
// Shared types and constants of the pump safety interlock unit: payload
// structures, configuration register map, reset values and channel indexes.
// ----------------------------------------------------------------------------
package psi_pkg;

  localparam int MV_W    = 12;
  localparam int TEMP_W  = 12;
  localparam int STAMP_W = 32;
  localparam int NCH     = 4;
  localparam int NFAULT  = 6;

  // Channel order inside the averaging windows.
  localparam int CH_PRE  = 0;
  localparam int CH_POST = 1;
  localparam int CH_MEM  = 2;
  localparam int CH_SAL  = 3;

  // Fault bit positions.
  localparam int F_TDI   = 0;
  localparam int F_PRE   = 1;
  localparam int F_DROP  = 2;
  localparam int F_MEM   = 3;
  localparam int F_BOOST = 4;
  localparam int F_HP    = 5;

  // Temperatures above this many sixteenths of a degree (90 C) are a fault.
  localparam logic signed [TEMP_W-1:0] TEMP_LIMIT = 12'sd1440;

  // Configuration register map (index = paddr / 4).
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TDI_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFILTER_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREFILTER_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_DROP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBRANE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBRANE_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_DELAY = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_DELAY = 3'd7;

  localparam logic [MV_W-1:0]    RST_TDI_LIMIT     = 12'd1150;
  localparam logic [MV_W-1:0]    RST_PREFILTER_MIN = 12'd717;
  localparam logic [MV_W-1:0]    RST_PREFILTER_MAX = 12'd1510;
  localparam logic [MV_W-1:0]    RST_FILTER_DROP   = 12'd159;
  localparam logic [MV_W-1:0]    RST_MEMBRANE_MIN  = 12'd1693;
  localparam logic [MV_W-1:0]    RST_MEMBRANE_MAX  = 12'd1873;
  localparam logic [STAMP_W-1:0] RST_STARTUP_DELAY = 32'd60000;
  localparam logic [STAMP_W-1:0] RST_RESTART_DELAY = 32'd60000;

  typedef struct packed {
    logic [MV_W-1:0]    tdi_limit_mv;
    logic [MV_W-1:0]    prefilter_min_mv;
    logic [MV_W-1:0]    prefilter_max_mv;
    logic [MV_W-1:0]    filter_drop_max_mv;
    logic [MV_W-1:0]    membrane_min_mv;
    logic [MV_W-1:0]    membrane_max_mv;
    logic [STAMP_W-1:0] startup_delay_ms;
    logic [STAMP_W-1:0] restart_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [STAMP_W-1:0]       now_ms;
    logic [MV_W-1:0]          prefilter_mv;
    logic [MV_W-1:0]          postfilter_mv;
    logic [MV_W-1:0]          membrane_mv;
    logic [MV_W-1:0]          salinity_mv;
    logic signed [TEMP_W-1:0] boost_temp;
    logic signed [TEMP_W-1:0] hp_temp;
  } sample_t;

  typedef struct packed {
    logic               relay_on;
    logic               checked;
    logic [NFAULT-1:0]  fault_bits;
    logic               stopped_now;
    logic               restarted_now;
    logic [STAMP_W-1:0] run_time_ms;
  } result_t;

endpackage

// File: rtl/psi_stream_if.sv
// ----------------------------------------------------------------------------
// psi_stream_if
// Valid/ready stream channel carrying one payload structure per transaction.
// ----------------------------------------------------------------------------
interface psi_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/psi_cfg_regs.sv
// ----------------------------------------------------------------------------
// psi_cfg_regs
// APB-style configuration register file holding thresholds and delays.
// ----------------------------------------------------------------------------
module psi_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [psi_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [psi_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [psi_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output psi_pkg::cfg_t                    cfg
);

  logic                            wr_en;
  logic [psi_pkg::CFG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[psi_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tdi_limit_mv       <= psi_pkg::RST_TDI_LIMIT;
      cfg.prefilter_min_mv   <= psi_pkg::RST_PREFILTER_MIN;
      cfg.prefilter_max_mv   <= psi_pkg::RST_PREFILTER_MAX;
      cfg.filter_drop_max_mv <= psi_pkg::RST_FILTER_DROP;
      cfg.membrane_min_mv    <= psi_pkg::RST_MEMBRANE_MIN;
      cfg.membrane_max_mv    <= psi_pkg::RST_MEMBRANE_MAX;
      cfg.startup_delay_ms   <= psi_pkg::RST_STARTUP_DELAY;
      cfg.restart_delay_ms   <= psi_pkg::RST_RESTART_DELAY;
    end else if (wr_en) begin
      unique case (idx)
        psi_pkg::REG_TDI_LIMIT:     cfg.tdi_limit_mv       <= pwdata[psi_pkg::MV_W-1:0];
        psi_pkg::REG_PREFILTER_MIN: cfg.prefilter_min_mv   <= pwdata[psi_pkg::MV_W-1:0];
        psi_pkg::REG_PREFILTER_MAX: cfg.prefilter_max_mv   <= pwdata[psi_pkg::MV_W-1:0];
        psi_pkg::REG_FILTER_DROP:   cfg.filter_drop_max_mv <= pwdata[psi_pkg::MV_W-1:0];
        psi_pkg::REG_MEMBRANE_MIN:  cfg.membrane_min_mv    <= pwdata[psi_pkg::MV_W-1:0];
        psi_pkg::REG_MEMBRANE_MAX:  cfg.membrane_max_mv    <= pwdata[psi_pkg::MV_W-1:0];
        psi_pkg::REG_STARTUP_DELAY: cfg.startup_delay_ms   <= pwdata;
        psi_pkg::REG_RESTART_DELAY: cfg.restart_delay_ms   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      psi_pkg::REG_TDI_LIMIT:     prdata = 32'(cfg.tdi_limit_mv);
      psi_pkg::REG_PREFILTER_MIN: prdata = 32'(cfg.prefilter_min_mv);
      psi_pkg::REG_PREFILTER_MAX: prdata = 32'(cfg.prefilter_max_mv);
      psi_pkg::REG_FILTER_DROP:   prdata = 32'(cfg.filter_drop_max_mv);
      psi_pkg::REG_MEMBRANE_MIN:  prdata = 32'(cfg.membrane_min_mv);
      psi_pkg::REG_MEMBRANE_MAX:  prdata = 32'(cfg.membrane_max_mv);
      psi_pkg::REG_STARTUP_DELAY: prdata = cfg.startup_delay_ms;
      psi_pkg::REG_RESTART_DELAY: prdata = cfg.restart_delay_ms;
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: rtl/psi_window.sv
// ----------------------------------------------------------------------------
// psi_window
// Four moving-average windows sharing one sample store, write slot and fill
// count. Presents the updated sums and count for the item being processed.
// ----------------------------------------------------------------------------
module psi_window #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 16,
  parameter int CNT_W  = 4,
  parameter int SLOT_W = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  psi_pkg::sample_t                    sample,
  output logic [psi_pkg::NCH-1:0][SUM_W-1:0]  sums_next,
  output logic [CNT_W-1:0]                    count_next
);

  localparam int ROW_W = psi_pkg::NCH * psi_pkg::MV_W;

  // One row holds the four readings of one sample period; never reset.
  logic [ROW_W-1:0]                    rows [WINDOW];
  logic [psi_pkg::NCH-1:0][SUM_W-1:0]  sums;
  logic [CNT_W-1:0]                    count;
  logic [SLOT_W-1:0]                   slot;
  logic [SLOT_W-1:0]                   slot_next;
  logic                                full;
  logic [ROW_W-1:0]                    new_row;
  logic [ROW_W-1:0]                    old_row;

  assign new_row = {sample.salinity_mv, sample.membrane_mv,
                    sample.postfilter_mv, sample.prefilter_mv};
  assign old_row = rows[slot];
  assign full    = (count == CNT_W'(WINDOW));

  always_comb begin
    for (int ch = 0; ch < psi_pkg::NCH; ch++) begin
      sums_next[ch] = sums[ch]
                    - (full ? SUM_W'(old_row[ch*psi_pkg::MV_W +: psi_pkg::MV_W]) : '0)
                    + SUM_W'(new_row[ch*psi_pkg::MV_W +: psi_pkg::MV_W]);
    end
  end

  assign count_next = full ? count : count + 1'b1;
  assign slot_next  = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums  <= '0;
      count <= '0;
      slot  <= '0;
    end else if (advance) begin
      sums  <= sums_next;
      count <= count_next;
      slot  <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rows[slot] <= new_row;
    end
  end

endmodule

// File: rtl/psi_interlock.sv
// ----------------------------------------------------------------------------
// psi_interlock
// Fault checks against averaged thresholds and the run/stop/restart state of
// the pump relay. Produces the result of the item being processed.
// ----------------------------------------------------------------------------
module psi_interlock #(
  parameter int SUM_W = 16,
  parameter int CNT_W = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  psi_pkg::cfg_t                       cfg,
  input  psi_pkg::sample_t                    sample,
  input  logic [psi_pkg::NCH-1:0][SUM_W-1:0]  sums,
  input  logic [CNT_W-1:0]                    count,
  output psi_pkg::result_t                    result
);

  localparam int THR_W = psi_pkg::MV_W + CNT_W;
  localparam int CMP_W = ((SUM_W > THR_W) ? SUM_W : THR_W) + 1;
  localparam int DRP_W = CMP_W + 1;

  logic                          running;
  logic [psi_pkg::STAMP_W-1:0]   start_stamp;
  logic [psi_pkg::STAMP_W-1:0]   stop_stamp;
  logic                          running_next;
  logic [psi_pkg::STAMP_W-1:0]   start_stamp_next;
  logic [psi_pkg::STAMP_W-1:0]   stop_stamp_next;

  logic [CMP_W-1:0]              pre, post, mem, sal;
  logic [CMP_W-1:0]              thr_tdi, thr_pre_min, thr_pre_max;
  logic [CMP_W-1:0]              thr_drop, thr_mem_min, thr_mem_max;
  logic signed [DRP_W-1:0]       drop;
  logic [psi_pkg::NFAULT-1:0]    faults;
  logic                          checks_on;
  logic                          stop;
  logic                          restart;

  assign pre  = CMP_W'(sums[psi_pkg::CH_PRE]);
  assign post = CMP_W'(sums[psi_pkg::CH_POST]);
  assign mem  = CMP_W'(sums[psi_pkg::CH_MEM]);
  assign sal  = CMP_W'(sums[psi_pkg::CH_SAL]);

  // Thresholds scaled by the number of samples in the window.
  assign thr_tdi     = CMP_W'(THR_W'(cfg.tdi_limit_mv) * THR_W'(count));
  assign thr_pre_min = CMP_W'(THR_W'(cfg.prefilter_min_mv) * THR_W'(count));
  assign thr_pre_max = CMP_W'(THR_W'(cfg.prefilter_max_mv) * THR_W'(count));
  assign thr_drop    = CMP_W'(THR_W'(cfg.filter_drop_max_mv) * THR_W'(count));
  assign thr_mem_min = CMP_W'(THR_W'(cfg.membrane_min_mv) * THR_W'(count));
  assign thr_mem_max = CMP_W'(THR_W'(cfg.membrane_max_mv) * THR_W'(count));

  assign drop = $signed({1'b0, pre}) - $signed({1'b0, post});

  always_comb begin
    faults                  = '0;
    faults[psi_pkg::F_TDI]   = sal > thr_tdi;
    faults[psi_pkg::F_PRE]   = (pre < thr_pre_min) || (pre > thr_pre_max);
    faults[psi_pkg::F_DROP]  = drop > $signed({1'b0, thr_drop});
    faults[psi_pkg::F_MEM]   = (mem < thr_mem_min) || (mem > thr_mem_max);
    faults[psi_pkg::F_BOOST] = sample.boost_temp > psi_pkg::TEMP_LIMIT;
    faults[psi_pkg::F_HP]    = sample.hp_temp > psi_pkg::TEMP_LIMIT;
  end

  assign checks_on = running && ((sample.now_ms - start_stamp) > cfg.startup_delay_ms);
  assign stop      = checks_on && (|faults);
  // Restart looks at the state held before this item, so only a pump that
  // was already stopped can restart.
  assign restart   = !running && ((sample.now_ms - stop_stamp) > cfg.restart_delay_ms);

  assign running_next     = stop ? 1'b0 : (restart ? 1'b1 : running);
  assign start_stamp_next = restart ? sample.now_ms : start_stamp;
  assign stop_stamp_next  = stop ? sample.now_ms : stop_stamp;

  always_comb begin
    result.relay_on      = running_next;
    result.checked       = checks_on;
    result.fault_bits    = checks_on ? faults : '0;
    result.stopped_now   = stop;
    result.restarted_now = restart;
    result.run_time_ms   = running_next ? (sample.now_ms - start_stamp_next)
                                        : (stop_stamp_next - start_stamp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b1;
      start_stamp <= '0;
      stop_stamp  <= '0;
    end else if (advance) begin
      running     <= running_next;
      start_stamp <= start_stamp_next;
      stop_stamp  <= stop_stamp_next;
    end
  end

endmodule

// File: rtl/pump_safety_interlock_unit.sv
// ----------------------------------------------------------------------------
// pump_safety_interlock_unit
// Top level of the pump safety interlock: input register, averaging windows,
// fault checks with run/stop/restart control, result register and APB port.
// ----------------------------------------------------------------------------
// Each transaction on the samples channel is one sample period and produces
// exactly one transaction on the verdicts channel. The unit accepts a new
// sample every clock cycle while verdicts are taken. A sample lands in the
// input register on the edge that accepts it, and its verdict is written to
// the result register once that register is free or is being emptied. The
// sustained rate of one sample per cycle rests on the window sums and pump
// state being updated combinationally between those two registers. A verdict
// that waits on the downstream side does not block the next sample from being
// captured in the input register; only a second sample behind it is held off
// until the verdict leaves. The four millivolt readings are averaged over the
// last WINDOW samples (fewer while the windows fill); averages are compared as
// sum against threshold times sample count. Faults are checked only while the
// pump runs and once more than startup_delay_ms has passed since it started;
// any fault drops the relay, and it closes again once it has been open for
// more than restart_delay_ms. After reset the pump runs.
// Thresholds and delays sit in eight 32-bit APB registers at byte addresses
// 0x00 through 0x1C and should be written only while no sample is in flight.
// ----------------------------------------------------------------------------
module pump_safety_interlock_unit #(
  parameter int WINDOW = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  psi_stream_if.sink                      samples,
  psi_stream_if.source                    verdicts,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [psi_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [psi_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [psi_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  // Widths derived from the window depth.
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = $clog2(WINDOW * ((1 << psi_pkg::MV_W) - 1) + 1);

  psi_pkg::cfg_t                       cfg;
  psi_pkg::sample_t                    in_data;
  logic                                in_valid;
  psi_pkg::result_t                    result;
  psi_pkg::result_t                    out_data;
  logic                                out_valid;
  logic                                advance;
  logic [psi_pkg::NCH-1:0][SUM_W-1:0]  sums_next;
  logic [CNT_W-1:0]                    count_next;

  // The held sample is processed whenever the result register is free or
  // is being emptied in this same cycle.
  assign advance       = in_valid && (!out_valid || verdicts.ready);
  assign samples.ready = !in_valid || advance;

  assign verdicts.valid = out_valid;
  assign verdicts.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      in_data <= samples.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (verdicts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  psi_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psi_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .CNT_W  (CNT_W),
    .SLOT_W (SLOT_W)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .sample     (in_data),
    .sums_next  (sums_next),
    .count_next (count_next)
  );

  psi_interlock #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_interlock (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .sample  (in_data),
    .sums    (sums_next),
    .count   (count_next),
    .result  (result)
  );

  // A stop and a restart can never fall on the same sample.
  a_no_stop_and_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.stopped_now && out_data.restarted_now))
    else $error("stop and restart reported on the same sample");

  // A stop comes only from an evaluated check with at least one fault.
  a_stop_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stopped_now) |->
      (out_data.checked && !out_data.relay_on && (out_data.fault_bits != '0)))
    else $error("stop reported without an evaluated fault");

  // Fault bits stay clear when checks were not evaluated.
  a_faults_need_check: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.checked) |-> (out_data.fault_bits == '0))
    else $error("fault bits set on an unchecked sample");

  // A restart closes the relay with the run timer at zero.
  a_restart_resets_timer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.restarted_now) |->
      (out_data.relay_on && (out_data.run_time_ms == '0)))
    else $error("restart without relay on and zero run time");

  // With both registers full and the output stalled, no sample may enter.
  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !verdicts.ready) |-> !samples.ready)
    else $error("sample accepted while pipeline is full and stalled");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the pump safety interlock unit. Samples go in on
// a valid/ready channel and verdicts come out on another. Both sides idle at
// random. Each verdict is checked field by field against a built-in predictor
// or, for the first directed samples, against values typed into the short
// table that opens the run. It then walks through several register settings,
// the extremes among them, with random samples carrying advancing timestamps.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_LEN    = 10;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 145;
  localparam int SETTLE_CYCLES = 8;
  localparam int SHOW_LIMIT    = 40;

  // Readings of a healthy plant under the reset thresholds.
  localparam int NOM_PRE  = 1000;
  localparam int NOM_POST = 950;
  localparam int NOM_MEM  = 1780;
  localparam int NOM_SAL  = 500;
  localparam int NOM_TEMP = 400;

  typedef struct {
    psi_pkg::sample_t smp;
    bit               typed;
    logic [31:0]      typed_run;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [psi_pkg::CFG_ADDR_W-1:0] paddr;
  logic [psi_pkg::CFG_DATA_W-1:0] pwdata;
  logic [psi_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  psi_stream_if #(.payload_t(psi_pkg::sample_t)) sample_ch ();
  psi_stream_if #(.payload_t(psi_pkg::result_t)) verdict_ch ();

  pump_safety_interlock_unit #(
    .WINDOW (WINDOW_LEN)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_ch),
    .verdicts (verdict_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: the averaging windows, the pump state machine and a copy
  // of the register settings, all kept in step with the accepted samples.
  logic [psi_pkg::MV_W-1:0] win_hist [psi_pkg::NCH][WINDOW_LEN];
  logic [31:0]              win_sum [psi_pkg::NCH];
  int unsigned              fill_count;
  int unsigned              write_pos;
  logic                     pump_running;
  logic [31:0]              started_at;
  logic [31:0]              stopped_at;
  psi_pkg::cfg_t            active_cfg;

  psi_pkg::result_t pending_verdicts [$];
  dir_row_t         directed_rows [$];

  int tx_gap_max   = 0;
  int rx_stall_max = 0;

  int fail_count    = 0;
  int samples_sent  = 0;
  int verdicts_seen = 0;
  int checked_count = 0;
  int stop_count    = 0;
  int restart_count = 0;
  int settings_used = 1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run is bounded well above the slowest legal run: every sample waiting
  // out the longest sender gap and receiver stall, plus the register writes.
  initial begin
    #(2_000_000);
    $display("[pump_safety_interlock_unit] ERROR");
    $finish;
  end

  // Works out the verdict of one sample and advances the predictor state.
  // Averages are compared as window sum against threshold times fill count.
  function automatic psi_pkg::result_t predict_verdict(input psi_pkg::sample_t smp);
    logic [psi_pkg::MV_W-1:0] reading [psi_pkg::NCH];
    psi_pkg::result_t         r;
    logic [31:0]              cnt;
    logic [31:0]              elapsed;
    longint                   drop;
    reading[psi_pkg::CH_PRE]  = smp.prefilter_mv;
    reading[psi_pkg::CH_POST] = smp.postfilter_mv;
    reading[psi_pkg::CH_MEM]  = smp.membrane_mv;
    reading[psi_pkg::CH_SAL]  = smp.salinity_mv;
    for (int ch = 0; ch < psi_pkg::NCH; ch++) begin
      // Old samples leave a sum only once the window is full.
      if (fill_count >= WINDOW_LEN) begin
        win_sum[ch] -= 32'(win_hist[ch][write_pos]);
      end
      win_hist[ch][write_pos] = reading[ch];
      win_sum[ch] += 32'(reading[ch]);
    end
    if (fill_count < WINDOW_LEN) begin
      fill_count++;
    end
    write_pos = (write_pos + 1 >= WINDOW_LEN) ? 0 : write_pos + 1;
    cnt = fill_count;

    r = '0;
    elapsed = smp.now_ms - started_at;
    if (pump_running && elapsed > active_cfg.startup_delay_ms) begin
      r.checked = 1'b1;
      if (win_sum[psi_pkg::CH_SAL] > 32'(active_cfg.tdi_limit_mv) * cnt) begin
        r.fault_bits[psi_pkg::F_TDI] = 1'b1;
      end
      if (win_sum[psi_pkg::CH_PRE] < 32'(active_cfg.prefilter_min_mv) * cnt ||
          win_sum[psi_pkg::CH_PRE] > 32'(active_cfg.prefilter_max_mv) * cnt) begin
        r.fault_bits[psi_pkg::F_PRE] = 1'b1;
      end
      // The drop is signed, so a post-filter reading above the pre-filter
      // reading never faults.
      drop = longint'(win_sum[psi_pkg::CH_PRE]) - longint'(win_sum[psi_pkg::CH_POST]);
      if (drop > longint'(active_cfg.filter_drop_max_mv) * longint'(cnt)) begin
        r.fault_bits[psi_pkg::F_DROP] = 1'b1;
      end
      if (win_sum[psi_pkg::CH_MEM] < 32'(active_cfg.membrane_min_mv) * cnt ||
          win_sum[psi_pkg::CH_MEM] > 32'(active_cfg.membrane_max_mv) * cnt) begin
        r.fault_bits[psi_pkg::F_MEM] = 1'b1;
      end
      if ($signed(smp.boost_temp) > psi_pkg::TEMP_LIMIT) begin
        r.fault_bits[psi_pkg::F_BOOST] = 1'b1;
      end
      if ($signed(smp.hp_temp) > psi_pkg::TEMP_LIMIT) begin
        r.fault_bits[psi_pkg::F_HP] = 1'b1;
      end
      if (r.fault_bits != '0) begin
        pump_running  = 1'b0;
        stopped_at    = smp.now_ms;
        r.stopped_now = 1'b1;
      end
    end

    // A stop and a restart never fall on the same sample: right after a stop
    // the time since the stop is zero.
    elapsed = smp.now_ms - stopped_at;
    if (!pump_running && elapsed > active_cfg.restart_delay_ms) begin
      pump_running    = 1'b1;
      started_at      = smp.now_ms;
      r.restarted_now = 1'b1;
    end

    r.relay_on    = pump_running;
    r.run_time_ms = pump_running ? smp.now_ms - started_at : stopped_at - started_at;
    return r;
  endfunction

  function automatic logic [psi_pkg::MV_W-1:0] clip_mv(input int v);
    if (v < 0) begin
      return '0;
    end
    if (v > 4095) begin
      return '1;
    end
    return psi_pkg::MV_W'(v);
  endfunction

  // Mostly a reading around the band [lo, hi], with its edges hit exactly now
  // and then, and an occasional reading anywhere in the converter range.
  function automatic logic [psi_pkg::MV_W-1:0] near_band(input int lo, input int hi);
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return clip_mv($urandom_range(0, 4095));
      1: return clip_mv(lo);
      2: return clip_mv(hi);
      default: return clip_mv($urandom_range(clip_mv(lo - 20), clip_mv(hi + 20)));
    endcase
  endfunction

  function automatic logic signed [psi_pkg::TEMP_W-1:0] draw_temp();
    int t;
    case ($urandom_range(0, 9))
      0: t = int'($urandom_range(0, 2880)) - 880;
      1: t = int'(psi_pkg::TEMP_LIMIT);
      2: t = int'(psi_pkg::TEMP_LIMIT) + 1;
      3: t = -880;
      default: t = int'($urandom_range(0, 2200)) - 880;
    endcase
    return psi_pkg::TEMP_W'(t);
  endfunction

  function automatic logic [31:0] draw_delay();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      return $urandom_range(0, 40);
    end
    if (pick < 9) begin
      return '0;
    end
    return $urandom;
  endfunction

  // Millivolt registers are 12 bits wide; junk in the upper bits of the bus
  // word must be dropped by the block.
  function automatic logic [psi_pkg::CFG_DATA_W-1:0] pad_mv(
      input logic [psi_pkg::MV_W-1:0] v, input bit junk);
    logic [psi_pkg::CFG_DATA_W-psi_pkg::MV_W-1:0] upper;
    upper = junk ? (psi_pkg::CFG_DATA_W-psi_pkg::MV_W)'($urandom) : '0;
    return {upper, v};
  endfunction

  function automatic void add_row(input logic [31:0] now, input int pre, input int post,
                                  input int mem, input int sal, input int bt, input int ht,
                                  input bit typed, input logic [31:0] run);
    dir_row_t row;
    row.smp.now_ms        = now;
    row.smp.prefilter_mv  = psi_pkg::MV_W'(pre);
    row.smp.postfilter_mv = psi_pkg::MV_W'(post);
    row.smp.membrane_mv   = psi_pkg::MV_W'(mem);
    row.smp.salinity_mv   = psi_pkg::MV_W'(sal);
    row.smp.boost_temp    = psi_pkg::TEMP_W'(bt);
    row.smp.hp_temp       = psi_pkg::TEMP_W'(ht);
    row.typed             = typed;
    row.typed_run         = run;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endfunction

  // One APB write: a setup cycle, then an access cycle that completes on the
  // edge where pready is high. The predictor copy follows with the same width
  // masking as the block.
  task automatic write_register(input logic [psi_pkg::CFG_IDX_W-1:0] idx,
                                input logic [psi_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      psi_pkg::REG_TDI_LIMIT:     active_cfg.tdi_limit_mv       = value[psi_pkg::MV_W-1:0];
      psi_pkg::REG_PREFILTER_MIN: active_cfg.prefilter_min_mv   = value[psi_pkg::MV_W-1:0];
      psi_pkg::REG_PREFILTER_MAX: active_cfg.prefilter_max_mv   = value[psi_pkg::MV_W-1:0];
      psi_pkg::REG_FILTER_DROP:   active_cfg.filter_drop_max_mv = value[psi_pkg::MV_W-1:0];
      psi_pkg::REG_MEMBRANE_MIN:  active_cfg.membrane_min_mv    = value[psi_pkg::MV_W-1:0];
      psi_pkg::REG_MEMBRANE_MAX:  active_cfg.membrane_max_mv    = value[psi_pkg::MV_W-1:0];
      psi_pkg::REG_STARTUP_DELAY: active_cfg.startup_delay_ms   = value;
      psi_pkg::REG_RESTART_DELAY: active_cfg.restart_delay_ms   = value;
      default: ;
    endcase
  endtask

  task automatic program_settings(input psi_pkg::cfg_t c, input bit junk);
    write_register(psi_pkg::REG_TDI_LIMIT,     pad_mv(c.tdi_limit_mv, junk));
    write_register(psi_pkg::REG_PREFILTER_MIN, pad_mv(c.prefilter_min_mv, junk));
    write_register(psi_pkg::REG_PREFILTER_MAX, pad_mv(c.prefilter_max_mv, junk));
    write_register(psi_pkg::REG_FILTER_DROP,   pad_mv(c.filter_drop_max_mv, junk));
    write_register(psi_pkg::REG_MEMBRANE_MIN,  pad_mv(c.membrane_min_mv, junk));
    write_register(psi_pkg::REG_MEMBRANE_MAX,  pad_mv(c.membrane_max_mv, junk));
    write_register(psi_pkg::REG_STARTUP_DELAY, c.startup_delay_ms);
    write_register(psi_pkg::REG_RESTART_DELAY, c.restart_delay_ms);
    settings_used++;
  endtask

  // Offers one sample after a random gap and holds it until it is taken. The
  // expectation is queued on the very edge where the transaction happens.
  task automatic send_sample(input psi_pkg::sample_t smp, input bit typed,
                             input psi_pkg::result_t typed_res);
    int               gap;
    psi_pkg::result_t predicted;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= smp;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = predict_verdict(smp);
    pending_verdicts.push_back(typed ? typed_res : predicted);
    samples_sent++;
  endtask

  // Stops the sender and waits for every outstanding verdict, then lets the
  // pipeline settle so that the block is idle.
  task automatic wait_for_idle();
    sample_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: before each verdict it stalls for a random number of cycles,
  // then keeps ready high until a verdict transaction goes through.
  initial begin : verdict_sink
    int stall;
    verdict_ch.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        verdict_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      verdict_ch.ready <= 1'b1;
      do @(posedge clk); while (verdict_ch.valid !== 1'b1);
    end
  end

  // Every verdict transaction is compared with the oldest expectation.
  always @(posedge clk) begin : verdict_check
    psi_pkg::result_t want;
    psi_pkg::result_t got;
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      got = verdict_ch.data;
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        $display("%0t: verdict expected none, actual %p", $time, got);
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_seen++;
        if (want.checked) checked_count++;
        if (want.stopped_now) stop_count++;
        if (want.restarted_now) restart_count++;
        check_field("relay_on", want.relay_on, got.relay_on);
        check_field("checked", want.checked, got.checked);
        check_field("fault_bits", want.fault_bits, got.fault_bits);
        check_field("stopped_now", want.stopped_now, got.stopped_now);
        check_field("restarted_now", want.restarted_now, got.restarted_now);
        check_field("run_time_ms", want.run_time_ms, got.run_time_ms);
      end
    end
  end

  initial begin : stimulus
    psi_pkg::sample_t smp;
    psi_pkg::result_t quiet;
    psi_pkg::cfg_t    next_cfg;
    logic [31:0]      clock_ms;
    int               post_v;

    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;

    // The predictor starts from the reset state: empty windows, pump running
    // since time zero, registers at their reset values.
    for (int ch = 0; ch < psi_pkg::NCH; ch++) begin
      win_sum[ch] = '0;
    end
    fill_count   = 0;
    write_pos    = 0;
    pump_running = 1'b1;
    started_at   = '0;
    stopped_at   = '0;
    active_cfg.tdi_limit_mv       = psi_pkg::RST_TDI_LIMIT;
    active_cfg.prefilter_min_mv   = psi_pkg::RST_PREFILTER_MIN;
    active_cfg.prefilter_max_mv   = psi_pkg::RST_PREFILTER_MAX;
    active_cfg.filter_drop_max_mv = psi_pkg::RST_FILTER_DROP;
    active_cfg.membrane_min_mv    = psi_pkg::RST_MEMBRANE_MIN;
    active_cfg.membrane_max_mv    = psi_pkg::RST_MEMBRANE_MAX;
    active_cfg.startup_delay_ms   = psi_pkg::RST_STARTUP_DELAY;
    active_cfg.restart_delay_ms   = psi_pkg::RST_RESTART_DELAY;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table, run under the reset settings. The first rows fall inside
    // the startup delay, so their verdicts are plain: relay closed, no checks,
    // run time equal to the timestamp. They also fill the windows with extreme
    // readings that later rows push out again.
    add_row(0, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b1, 0);
    add_row(1000, 4095, 4095, 4095, 4095, 2000, 2000, 1'b1, 1000);
    add_row(60000, 0, 0, 0, 0, -880, -880, 1'b1, 60000);
    for (int k = 0; k < 7; k++) begin
      add_row(60000, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b1, 60000);
    end
    // Checks begin one millisecond past the delay; once the window of
    // full-scale readings leaves, the membrane average sags and the pump stops.
    add_row(60001, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b0, 0);
    add_row(60002, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b0, 0);
    // Exactly the restart delay does not restart; one more millisecond does.
    add_row(120002, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b0, 0);
    add_row(120003, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b0, 0);
    // Boost pump one step over the temperature limit, the other exactly at it.
    add_row(180004, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, 1441, 1440, 1'b0, 0);
    add_row(240005, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b0, 0);
    // Large positive filter drop with the hottest pump reading.
    add_row(300006, 4095, 0, NOM_MEM, NOM_SAL, NOM_TEMP, 2000, 1'b0, 0);
    add_row(360007, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b0, 0);
    // Negative drop, which must never fault, and the coldest readings.
    add_row(420008, 0, 4095, 4095, 4095, -880, -880, 1'b0, 0);
    add_row(480009, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b0, 0);
    // The timestamp wraps around; differences are taken modulo 2^32.
    add_row(32'hFFFF_FFFF, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b0, 0);
    add_row(5, NOM_PRE, NOM_POST, NOM_MEM, NOM_SAL, NOM_TEMP, NOM_TEMP, 1'b0, 0);

    tx_gap_max   = 9;
    rx_stall_max = 9;
    foreach (directed_rows[i]) begin
      quiet             = '0;
      quiet.relay_on    = 1'b1;
      quiet.run_time_ms = directed_rows[i].typed_run;
      send_sample(directed_rows[i].smp, directed_rows[i].typed, quiet);
    end
    wait_for_idle();

    // Random part: one register setting per phase, the first three at the
    // extremes (all zero, all ones, and limits wide open with no delays).
    clock_ms = '0;
    for (int phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
      case (phase_idx)
        0: next_cfg = '0;
        1: next_cfg = '1;
        2: begin
          next_cfg                    = '0;
          next_cfg.tdi_limit_mv       = '1;
          next_cfg.prefilter_max_mv   = '1;
          next_cfg.filter_drop_max_mv = '1;
          next_cfg.membrane_max_mv    = '1;
        end
        default: begin
          next_cfg.tdi_limit_mv       = psi_pkg::MV_W'($urandom_range(300, 2500));
          next_cfg.prefilter_min_mv   = psi_pkg::MV_W'($urandom_range(0, 3000));
          next_cfg.prefilter_max_mv   = psi_pkg::MV_W'(next_cfg.prefilter_min_mv
                                                       + $urandom_range(0, 1095));
          next_cfg.filter_drop_max_mv = psi_pkg::MV_W'($urandom_range(0, 600));
          next_cfg.membrane_min_mv    = psi_pkg::MV_W'($urandom_range(0, 3000));
          next_cfg.membrane_max_mv    = psi_pkg::MV_W'(next_cfg.membrane_min_mv
                                                       + $urandom_range(0, 1095));
          next_cfg.startup_delay_ms   = draw_delay();
          next_cfg.restart_delay_ms   = draw_delay();
        end
      endcase
      program_settings(next_cfg, phase_idx >= 3 && $urandom_range(0, 1) == 1);

      // Idling patterns rotate so that some phases run with no gaps at all.
      case (phase_idx % 4)
        0: begin tx_gap_max = 9; rx_stall_max = 9; end
        1: begin tx_gap_max = 0; rx_stall_max = 0; end
        2: begin tx_gap_max = 9; rx_stall_max = 0; end
        default: begin tx_gap_max = 0; rx_stall_max = 9; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Timestamps mostly advance by a few milliseconds so that startup and
        // restart delays run out; now and then they jump anywhere.
        if ($urandom_range(0, 49) == 0) begin
          clock_ms = $urandom;
        end else begin
          clock_ms += $urandom_range(0, 25);
        end
        smp.now_ms       = clock_ms;
        smp.prefilter_mv = near_band(active_cfg.prefilter_min_mv,
                                     active_cfg.prefilter_max_mv);
        if ($urandom_range(0, 4) == 0) begin
          smp.postfilter_mv = psi_pkg::MV_W'($urandom_range(0, 4095));
        end else begin
          post_v = int'(smp.prefilter_mv) + 20
                   - int'($urandom_range(0, int'(active_cfg.filter_drop_max_mv) + 40));
          smp.postfilter_mv = clip_mv(post_v);
        end
        smp.membrane_mv = near_band(active_cfg.membrane_min_mv, active_cfg.membrane_max_mv);
        smp.salinity_mv = near_band(0, active_cfg.tdi_limit_mv);
        smp.boost_temp  = draw_temp();
        smp.hp_temp     = draw_temp();
        send_sample(smp, 1'b0, '0);
        // Now and then the sender holds off until every verdict is back.
        if ($urandom_range(0, 99) == 0) begin
          wait_for_idle();
        end
      end
      wait_for_idle();
    end

    $display("Sent %0d samples under %0d register settings and checked %0d verdicts.",
             samples_sent, settings_used, verdicts_seen);
    $display("Faults were evaluated on %0d samples, with %0d stops and %0d restarts.",
             checked_count, stop_count, restart_count);
    if (fail_count == 0) begin
      $display("[pump_safety_interlock_unit] OK");
    end else begin
      $display("[pump_safety_interlock_unit] ERROR");
    end
    $finish;
  end

endmodule
